// ----- sv/tcse_pkg.sv -----
// Package with the shared types, constants and the helper function of the tANS encoder.
`default_nettype none

package tcse_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ENCODE  = 2'd2,
    CMD_CLOSE   = 2'd3
  } cmd_e;

  // Escape entry: delta of probability one and the fixed next-state offset.
  localparam logic [11:0] ESC_DELTA  = 12'd2048;
  localparam logic [7:0]  ESC_OFFSET = 8'd254;
  localparam logic [19:0] ESC_ENTRY  = {ESC_DELTA, ESC_OFFSET};

  // Bit counts used by the packer.
  localparam logic [4:0] RAW_BITS   = 5'd6;
  localparam logic [4:0] CLOSE_BITS = 5'd9;
  localparam logic [4:0] BYTE_BITS  = 5'd8;
  localparam logic [4:0] MAX_FILL   = 5'd21;
  localparam logic [3:0] MAX_NB     = 4'd8;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // One operation handed from the front to the back.
  typedef struct packed {
    logic        is_close;
    logic        raw;
    logic [5:0]  symbol;
    logic [11:0] delta;
    logic [7:0]  offset;
  } tcse_op_t;

  // Renormalization delta for a nonzero probability count.
  function automatic logic [11:0] delta_for(input logic [7:0] pmf);
    logic [3:0] n;
    n = 4'd8;
    for (int k = 0; k < 8; k++) begin
      if (pmf[k]) begin
        n = 4'(8 - k);
      end
    end
    return {n, 8'd0} + 12'd256 - (12'(pmf) << n);
  endfunction

endpackage

`default_nettype wire

// ----- sv/tcse_in_if.sv -----
// Input channel interface: command, symbol and cumulative count with valid and ready.
`default_nettype none

interface tcse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] symbol;
  logic [7:0] cdf_value;

  modport source (output valid, output command, output symbol, output cdf_value,
                  input ready);
  modport sink (input valid, input command, input symbol, input cdf_value,
                output ready);
endinterface

`default_nettype wire

// ----- sv/tcse_out_if.sv -----
// Output channel interface: coded byte and last flag with valid and ready.
`default_nettype none

interface tcse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/tcse_front.sv -----
// Front end: command decode, transition table build and lookup, operation issue.
`default_nettype none

module tcse_front #(
  parameter int unsigned SYMBOLS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [5:0]        symbol_i,
  input  logic [7:0]        cdf_value_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output tcse_pkg::tcse_op_t op_o
);
  import tcse_pkg::*;

  localparam int unsigned AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [5:0] SYM_LIMIT = 6'(SYMBOLS);

  logic [19:0]        mem_q [SYMBOLS];
  logic [SYMBOLS-1:0] valid_q;
  logic [5:0]         load_pos_q;
  logic [7:0]         run_cdf_q;
  logic [19:0]        rdata_q;
  logic               s1_valid_q;
  logic               s1_close_q;
  logic               s1_hit_q;
  logic [5:0]         s1_sym_q;

  cmd_e        cmd;
  logic        acc;
  logic        load_we;
  logic        rd_en;
  logic        sym_in;
  logic [7:0]  pmf;
  logic [19:0] load_entry;
  logic [AW-1:0] load_idx;
  logic [AW-1:0] sym_idx;

  // Decode the accepted transaction.
  assign in_ready_o = !s1_valid_q || op_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);
  assign load_idx   = load_pos_q[AW-1:0];
  assign sym_idx    = symbol_i[AW-1:0];
  assign sym_in     = symbol_i < SYM_LIMIT;
  assign load_we    = acc && (cmd == CMD_LOAD) && (load_pos_q < SYM_LIMIT);
  assign rd_en      = acc && (cmd == CMD_ENCODE) && sym_in;

  // Entry build from the difference of cumulative counts.
  assign pmf        = cdf_value_i - run_cdf_q;
  assign load_entry = {delta_for(pmf), run_cdf_q - pmf};

  // Table memory with registered read port.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_q[load_idx] <= load_entry;
    end
    if (rd_en) begin
      rdata_q <= mem_q[sym_idx];
    end
  end

  // Entry valid bits and load pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      load_pos_q <= '0;
      run_cdf_q  <= '0;
    end else if (acc && (cmd == CMD_RESTART)) begin
      valid_q    <= '0;
      load_pos_q <= '0;
      run_cdf_q  <= '0;
    end else if (load_we) begin
      valid_q[load_idx] <= (pmf != 8'd0);
      load_pos_q        <= load_pos_q + 6'd1;
      run_cdf_q         <= cdf_value_i;
    end
  end

  // Lookup stage that holds an encode or close until the queue takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_close_q <= 1'b0;
      s1_hit_q   <= 1'b0;
      s1_sym_q   <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= acc && ((cmd == CMD_ENCODE) || (cmd == CMD_CLOSE));
      s1_close_q <= (cmd == CMD_CLOSE);
      s1_hit_q   <= sym_in && valid_q[sym_idx];
      s1_sym_q   <= symbol_i;
    end
  end

  // A missing entry falls back to the escape entry, with raw bits unless it is the escape index.
  always_comb begin
    op_valid_o     = s1_valid_q;
    op_o.is_close  = s1_close_q;
    op_o.raw       = !s1_hit_q && (s1_sym_q != SYM_LIMIT);
    op_o.symbol    = s1_sym_q;
    {op_o.delta, op_o.offset} = s1_hit_q ? rdata_q : ESC_ENTRY;
  end

  // A restart leaves the table empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd == CMD_RESTART) |=> (valid_q == '0) && (load_pos_q == 6'd0))
    else $error("table not cleared by restart");

  // The load pointer never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pos_q <= SYM_LIMIT)
    else $error("load pointer past table");

endmodule

`default_nettype wire

// ----- sv/tcse_fifo.sv -----
// Short operation queue between the front end and the coder back end.
`default_nettype none

module tcse_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  tcse_pkg::tcse_op_t wr_op_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output tcse_pkg::tcse_op_t rd_op_o
);
  import tcse_pkg::*;

  localparam logic [QUEUE_PTR_W:0] FULL_CNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

  tcse_op_t               slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   cnt_q;
  logic                   push;
  logic                   pop;

  assign wr_ready_o = cnt_q != FULL_CNT;
  assign rd_valid_o = cnt_q != '0;
  assign rd_op_o    = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // The fill count tracks a lone push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

  // The pointers stay apart by the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == FULL_CNT) ||
    (QUEUE_PTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[QUEUE_PTR_W-1:0]))
    else $error("queue pointers out of step");

endmodule

`default_nettype wire

// ----- sv/tcse_back.sv -----
// Back end: coder state update, bit packing and the output byte register.
`default_nettype none

module tcse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  input  tcse_pkg::tcse_op_t op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);
  import tcse_pkg::*;

  logic [7:0]  cs_q, cs_d;
  logic [23:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        close_q, close_d;
  logic        close_left_q, close_left_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        slot_free;
  logic        emit;
  logic        pop;
  logic [23:0] buf_e;
  logic [4:0]  cnt_e;
  logic [4:0]  cnt_r;
  logic [23:0] raw_bits;
  logic [12:0] sum;
  logic [3:0]  nb;
  logic [8:0]  mask;
  logic [8:0]  shifted;
  logic [7:0]  low;

  // Byte emission frees room before a new operation is taken.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit       = slot_free && (close_q || (cnt_q >= BYTE_BITS));
  assign buf_e      = emit ? (buf_q >> 8) : buf_q;
  assign cnt_e      = (emit && !close_q) ? (cnt_q - BYTE_BITS) : cnt_q;
  assign pop        = op_valid_i && !close_q && (cnt_e < BYTE_BITS);
  assign op_ready_o = !close_q && (cnt_e < BYTE_BITS);

  // Raw symbol bits, renormalization bits and next state for an encode.
  always_comb begin
    raw_bits = op_i.raw ? (24'(op_i.symbol) << cnt_e) : 24'd0;
    cnt_r    = op_i.raw ? (cnt_e + RAW_BITS) : cnt_e;
    sum      = 13'(cs_q) + 13'(op_i.delta);
    nb       = (sum[12:8] > 5'(MAX_NB)) ? MAX_NB : sum[11:8];
    mask     = (9'd1 << nb) - 9'd1;
    low      = cs_q & mask[7:0];
    shifted  = {1'b1, cs_q} >> nb;
  end

  // Next state of the coder and packer.
  always_comb begin
    cs_d         = cs_q;
    buf_d        = buf_e;
    cnt_d        = cnt_e;
    close_d      = close_q;
    close_left_d = close_left_q;
    if (close_q && emit) begin
      close_left_d = 1'b1;
      if (close_left_q) begin
        close_d      = 1'b0;
        close_left_d = 1'b0;
        buf_d        = '0;
        cnt_d        = '0;
      end
    end else if (pop) begin
      if (op_i.is_close) begin
        buf_d        = buf_e | (24'({1'b1, cs_q}) << cnt_e);
        cnt_d        = cnt_e + CLOSE_BITS;
        cs_d         = '0;
        close_d      = 1'b1;
        close_left_d = 1'b0;
      end else begin
        buf_d = buf_e | raw_bits | (24'(low) << cnt_r);
        cnt_d = cnt_r + 5'(nb);
        cs_d  = shifted[7:0] + op_i.offset;
      end
    end
  end

  // Coder registers and output byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q         <= '0;
      buf_q        <= '0;
      cnt_q        <= '0;
      close_q      <= 1'b0;
      close_left_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      cs_q         <= cs_d;
      buf_q        <= buf_d;
      cnt_q        <= cnt_d;
      close_q      <= close_d;
      close_left_q <= close_left_d;
      if (slot_free) begin
        out_valid_q <= emit;
        out_byte_q  <= buf_q[7:0];
        out_last_q  <= close_q && close_left_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // The packer never holds more bits than one operation can add to a partial byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_FILL)
    else $error("bit buffer overfilled");

  // A close always leaves at least nine bits to flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(close_q) |-> cnt_q >= CLOSE_BITS)
    else $error("close started without its tail bits");

endmodule

`default_nettype wire

// ----- sv/tans_cdf_symbol_encoder.sv -----
// Top level of the table-driven ANS symbol encoder with an 8-bit coder state.
// Usage: the input channel carries one command per transaction. Restart (0) empties the
// transition table, load (1) builds the next table entry from a cumulative count, encode (2)
// codes one symbol, and close (3) flushes the final state and ends the stream.
// The output channel carries the coded bytes, LSB-first packed; last_byte marks the second
// byte of a close. Restart and load produce no output bytes.
// Throughput: one command per cycle enters while input ready is high; table commands finish
// on their accepting edge. The coder takes one encode or close from its queue per cycle
// while fewer than eight bits are pending and no close is flushing, and the output register
// moves one byte per cycle while the receiver is ready; a close is appended first and then
// flushed as two bytes. A byte passes the table lookup stage, the queue, the coder and the
// output register in that order; the lookup memory read is the first.
// Stalls: when the receiver holds ready low the byte stays in the output register, the coder
// and its four-entry queue fill, and then input ready drops.
// Reset: the table is empty (every symbol takes the escape path), the load pointer, running
// count, coder state and bit buffer are zero; no clearing pass is needed.
`default_nettype none

module tans_cdf_symbol_encoder #(
  parameter int unsigned SYMBOLS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcse_in_if.sink    in_i,
  tcse_out_if.source out_o
);
  import tcse_pkg::*;

  logic     fr_valid;
  logic     fr_ready;
  tcse_op_t fr_op;
  logic     bk_valid;
  logic     bk_ready;
  tcse_op_t bk_op;

  // Command decode and table lookup.
  tcse_front #(
    .SYMBOLS(SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .command_i   (in_i.command),
    .symbol_i    (in_i.symbol),
    .cdf_value_i (in_i.cdf_value),
    .op_valid_o  (fr_valid),
    .op_ready_i  (fr_ready),
    .op_o        (fr_op)
  );

  // Queue between lookup and coder.
  tcse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_op_i    (fr_op),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_op_o    (bk_op)
  );

  // Coder and byte packer.
  tcse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_ready_o  (bk_ready),
    .op_i        (bk_op),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last_byte)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the tANS encoder: table loads, symbol coding and stream close.

module testbench;
  import tcse_pkg::*;

  localparam int SYMBOLS          = 32;
  localparam int PHASE_ITEMS      = 100;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 20;
  localparam logic [7:0] ESCAPE_OFFSET = 8'd254;
  localparam logic [4:0] RAW_WIDTH     = 5'd6;
  localparam logic [4:0] FLUSH_WIDTH   = 5'd9;

  // Traffic shapes applied to the two channels.
  typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_e;

  // One coded byte as it should leave the block.
  typedef struct {
    logic [7:0] value;
    logic       is_last;
  } coded_byte_t;

  // One row of the directed stimulus; byte_count below zero means "use the predictor".
  typedef struct {
    cmd_e        cmd;
    logic [5:0]  sym;
    logic [7:0]  cdf;
    int          reps;
    int          byte_count;
    logic [15:0] byte_pair;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcse_in_if  in_if ();
  tcse_out_if out_if ();

  tans_cdf_symbol_encoder #(.SYMBOLS(SYMBOLS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: transition table, loader and coder.
  logic [19:0] trans_table [0:SYMBOLS];
  logic [5:0]  load_pos;
  logic [7:0]  cdf_sum;
  logic [7:0]  coder_state;
  logic [23:0] bit_store;
  logic [4:0]  bit_fill;

  coded_byte_t coded_q[$];
  flow_e       flow = FLOW_FREE;
  int          fail_count = 0;
  int          items_done = 0;
  int          loads_seen = 0;
  int          idle_cycles = 0;
  int          typed_count = -1;
  logic [15:0] typed_pair = '0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_done = 1'b0;

  // Directed stimulus: reset behavior, close, table extremes and every coding path.
  stim_row_t directed_rows [0:21] = '{
    '{CMD_ENCODE,  6'd0,  8'd0,   1, 1,  16'h0000},  // empty table, escape from state zero
    '{CMD_CLOSE,   6'd0,  8'd0,   1, 2,  16'h7FC0},  // close from state 255
    '{CMD_CLOSE,   6'd63, 8'd255, 1, 2,  16'h0100},  // close from a clean stream
    '{CMD_RESTART, 6'd63, 8'd255, 1, -1, 16'h0000},
    '{CMD_LOAD,    6'd0,  8'd0,   1, -1, 16'h0000},  // zero probability
    '{CMD_LOAD,    6'd0,  8'd1,   1, -1, 16'h0000},  // probability one
    '{CMD_LOAD,    6'd0,  8'd128, 1, -1, 16'h0000},
    '{CMD_LOAD,    6'd0,  8'd255, 1, -1, 16'h0000},
    '{CMD_LOAD,    6'd0,  8'd100, 1, -1, 16'h0000},  // decreasing count wraps
    '{CMD_LOAD,    6'd0,  8'd99,  1, -1, 16'h0000},  // largest probability
    '{CMD_LOAD,    6'd0,  8'd200, 28, -1, 16'h0000}, // runs past the table end
    '{CMD_ENCODE,  6'd0,  8'd255, 1, -1, 16'h0000},  // zero-probability symbol
    '{CMD_ENCODE,  6'd1,  8'd0,   1, -1, 16'h0000},
    '{CMD_ENCODE,  6'd3,  8'd0,   1, -1, 16'h0000},
    '{CMD_ENCODE,  6'd5,  8'd0,   1, -1, 16'h0000},
    '{CMD_ENCODE,  6'd6,  8'd0,   1, -1, 16'h0000},
    '{CMD_ENCODE,  6'd32, 8'd0,   1, -1, 16'h0000},  // escape entry, no raw bits
    '{CMD_ENCODE,  6'd33, 8'd0,   1, -1, 16'h0000},  // symbol past the table
    '{CMD_ENCODE,  6'd63, 8'd0,   1, -1, 16'h0000},
    '{CMD_CLOSE,   6'd0,  8'd0,   1, -1, 16'h0000},
    '{CMD_RESTART, 6'd0,  8'd0,   1, -1, 16'h0000},
    '{CMD_ENCODE,  6'd1,  8'd0,   1, -1, 16'h0000}   // entry cleared by restart
  };

  // Renormalization delta of a nonzero probability count.
  function automatic logic [11:0] renorm_delta(input logic [7:0] pmf);
    logic [3:0]  shift;
    logic [11:0] scaled;
    shift = 4'd0;
    scaled = {4'd0, pmf};
    while (shift < 4'd8 && scaled < 12'd256) begin
      shift = shift + 4'd1;
      scaled = scaled << 1;
    end
    return {shift, 8'd0} + 12'd256 - scaled;
  endfunction

  // Appends bits to the pending stream, LSB first.
  task automatic append_bits(input logic [23:0] bits, input logic [4:0] count);
    bit_store = bit_store | (bits << bit_fill);
    bit_fill = bit_fill + count;
  endtask

  // Advances the encoder model by one command and returns the bytes it completes.
  task automatic advance_coder(input cmd_e cmd, input logic [5:0] sym, input logic [7:0] cdf,
                               output int n_bytes, output logic [15:0] byte_pair);
    logic [7:0]  pmf;
    logic [19:0] entry;
    logic [12:0] reach;
    logic [3:0]  nb;
    logic [8:0]  full_state;
    n_bytes = 0;
    byte_pair = '0;
    case (cmd)
      CMD_RESTART: begin
        for (int i = 0; i < SYMBOLS; i++) trans_table[i] = '0;
        load_pos = '0;
        cdf_sum = '0;
      end
      CMD_LOAD: begin
        if (load_pos < SYMBOLS) begin
          pmf = cdf - cdf_sum;
          trans_table[load_pos] = (pmf == 8'd0) ? 20'd0 :
                                  {renorm_delta(pmf), 8'(cdf_sum - pmf)};
          cdf_sum = cdf;
          load_pos = load_pos + 6'd1;
        end
      end
      CMD_ENCODE: begin
        entry = (sym <= SYMBOLS) ? trans_table[sym] : 20'd0;
        if (entry == 20'd0) begin
          append_bits(24'(sym), RAW_WIDTH);
          entry = {renorm_delta(8'd1), ESCAPE_OFFSET};
        end
        reach = 13'(coder_state) + 13'(entry[19:8]);
        nb = (reach[12:8] > 5'd8) ? 4'd8 : reach[11:8];
        full_state = {1'b1, coder_state};
        append_bits(24'(coder_state) & ((24'd1 << nb) - 24'd1), 5'(nb));
        coder_state = 8'((full_state >> nb) + 9'(entry[7:0]));
        while (bit_fill >= 5'd8 && n_bytes < 2) begin
          byte_pair[n_bytes*8 +: 8] = bit_store[7:0];
          bit_store = bit_store >> 8;
          bit_fill = bit_fill - 5'd8;
          n_bytes++;
        end
      end
      default: begin
        append_bits(24'({1'b1, coder_state}), FLUSH_WIDTH);
        byte_pair = bit_store[15:0];
        n_bytes = 2;
        coder_state = '0;
        bit_store = '0;
        bit_fill = '0;
      end
    endcase
  endtask

  function automatic logic sender_waits();
    if (flow == FLOW_SEND_IDLE) return $urandom_range(0, 99) < 82;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 20;
    return 1'b0;
  endfunction

  function automatic logic receiver_stalls();
    if (flow == FLOW_RECV_STALL) return $urandom_range(0, 99) < 82;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 20;
    return 1'b0;
  endfunction

  // Offers one command and waits until the block takes it.
  task automatic offer(input cmd_e cmd, input logic [5:0] sym, input logic [7:0] cdf,
                       input int byte_count, input logic [15:0] byte_pair);
    while (sender_waits()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    typed_count = byte_count;
    typed_pair = byte_pair;
    in_if.valid = 1'b1;
    in_if.command = cmd;
    in_if.symbol = sym;
    in_if.cdf_value = cdf;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    // Loads past the table end are ignored by the block and do not count.
    if (cmd == CMD_RESTART) loads_seen = 0;
    if (!(cmd == CMD_LOAD && loads_seen >= SYMBOLS)) items_done++;
    if (cmd == CMD_LOAD) loads_seen++;
  endtask

  task automatic offer_noise();
    offer(cmd_e'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
          8'($urandom_range(0, 255)), -1, '0);
  endtask

  // One well-formed stream: restart, table load, a run of symbols and usually a close.
  task automatic run_stream();
    int         n_loads;
    int         n_codes;
    int         pick;
    logic [7:0] acc;
    logic [5:0] sym;
    acc = '0;
    offer(CMD_RESTART, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), -1, '0);
    n_loads = ($urandom_range(0, 3) == 0) ? SYMBOLS + $urandom_range(1, 4)
                                          : $urandom_range(1, SYMBOLS);
    for (int i = 0; i < n_loads; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) acc = acc + 8'($urandom_range(1, 16));
      else if (pick == 9) acc = acc + 8'($urandom_range(0, 255));
      offer(CMD_LOAD, 6'($urandom_range(0, 63)), acc, -1, '0);
    end
    // The first stream also starts the long receiver hold-off.
    hold_off_req = 1'b1;
    n_codes = $urandom_range(5, 30);
    for (int i = 0; i < n_codes; i++) begin
      sym = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, SYMBOLS))
                                         : 6'($urandom_range(0, 63));
      offer(CMD_ENCODE, sym, 8'($urandom_range(0, 255)), -1, '0);
    end
    if ($urandom_range(0, 4) != 0) begin
      offer(CMD_CLOSE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), -1, '0);
    end
  endtask

  // Stimulus: reset, directed rows, then random streams across the traffic phases.
  initial begin : stimulus
    flow_e phases [5] = '{FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH, FLOW_FREE};
    int    target;
    in_if.valid = 1'b0;
    in_if.command = CMD_RESTART;
    in_if.symbol = '0;
    in_if.cdf_value = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        offer(directed_rows[r].cmd, directed_rows[r].sym, directed_rows[r].cdf,
              directed_rows[r].byte_count, directed_rows[r].byte_pair);
      end
    end

    foreach (phases[p]) begin
      flow = phases[p];
      target = items_done + PHASE_ITEMS;
      while (items_done < target) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 6)) offer_noise();
        end else begin
          run_stream();
        end
      end
    end

    in_if.valid = 1'b0;
    while (coded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off to back the block up.
  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_if.ready = 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
        out_if.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        out_if.ready = !receiver_stalls();
      end
    end
  end

  // Predictor state after reset: empty table with the escape entry preset.
  initial begin : model_reset
    foreach (trans_table[i]) trans_table[i] = '0;
    trans_table[SYMBOLS] = {renorm_delta(8'd1), ESCAPE_OFFSET};
    load_pos = '0;
    cdf_sum = '0;
    coder_state = '0;
    bit_store = '0;
    bit_fill = '0;
  end

  // Byte checking, expectation building and the stall watchdog.
  always @(posedge clk_i) begin : scoreboard
    coded_byte_t want;
    coded_byte_t made;
    int          n_bytes;
    logic [15:0] pair;
    cmd_e        cmd;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (coded_q.size() == 0) begin
          $error("out_byte: no byte expected, got %02h", out_if.out_byte);
          fail_count++;
        end else begin
          want = coded_q.pop_front();
          if (out_if.out_byte !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_if.out_byte);
            fail_count++;
          end
          if (out_if.last_byte !== want.is_last) begin
            $error("last_byte: expected %0b, got %0b", want.is_last, out_if.last_byte);
            fail_count++;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        cmd = cmd_e'(in_if.command);
        advance_coder(cmd, in_if.symbol, in_if.cdf_value, n_bytes, pair);
        // Rows with bytes typed in take those instead of the predicted ones.
        if (typed_count >= 0) begin
          n_bytes = typed_count;
          pair = typed_pair;
        end
        for (int k = 0; k < n_bytes; k++) begin
          made.value = pair[k*8 +: 8];
          made.is_last = (cmd == CMD_CLOSE) && (k == 1);
          coded_q.push_back(made);
        end
      end

      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
